### design/glmi_pkg.sv
`timescale 1ns / 1ps
package glmi_pkg;

  // input item kinds (in_tuser)
  localparam logic OP_MOVE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // configuration register indexes
  localparam int CFG_AW = 1;
  localparam logic [CFG_AW-1:0] CFG_DEFAULT_FEED = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_FIELD_SPAN   = 1'b1;

  localparam logic [23:0] DEFAULT_FEED_RST = 24'd256000;
  localparam logic [15:0] FIELD_SPAN_RST   = 16'd64000;

  // serial divider: 64-bit dividend, 48-bit divisor, one quotient bit per cycle
  localparam int DIV_DW = 64;
  localparam int DIV_VW = 48;

  // serial square root: 50-bit radicand, 25-bit root, one root bit per cycle
  localparam int SQ_VW = 50;
  localparam int SQ_RW = SQ_VW / 2;

  localparam logic [29:0] NS_PER_S = 30'd1000000000;
  localparam logic [15:0] GALVO_MAX = 16'hFFFF;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_DW-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic             start;
    logic [SQ_VW-1:0] radicand;
  } sq_req_t;

  typedef struct packed {
    logic             done;
    logic [SQ_RW-1:0] root;
  } sq_rsp_t;

endpackage

### design/glmi_ram.sv
`timescale 1ns / 1ps
module glmi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/glmi_div.sv
`timescale 1ns / 1ps
module glmi_div (
  input  logic              clk,
  input  logic              rst_n,
  input  glmi_pkg::div_req_t req,
  output glmi_pkg::div_rsp_t rsp
);
  import glmi_pkg::*;

  localparam int CW = $clog2(DIV_DW + 1);

  logic [DIV_VW-1:0] rem_r;
  logic [DIV_DW-1:0] quo_r;
  logic [DIV_VW-1:0] div_r;
  logic [CW-1:0]     cnt_r;
  logic              done_r;
  logic [DIV_VW:0]   trial;
  logic [DIV_VW:0]   diff;

  // restoring step: shift in next dividend bit, subtract if it fits
  assign trial = {rem_r, quo_r[DIV_DW-1]};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= !req.start && (cnt_r == CW'(1));
      if (req.start) begin
        rem_r <= '0;
        quo_r <= req.dividend;
        div_r <= req.divisor;
        cnt_r <= CW'(DIV_DW);
      end else if (cnt_r != '0) begin
        if (!diff[DIV_VW]) begin
          rem_r <= diff[DIV_VW-1:0];
          quo_r <= {quo_r[DIV_DW-2:0], 1'b1};
        end else begin
          rem_r <= trial[DIV_VW-1:0];
          quo_r <= {quo_r[DIV_DW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

### design/glmi_sqrt.sv
`timescale 1ns / 1ps
module glmi_sqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  glmi_pkg::sq_req_t req,
  output glmi_pkg::sq_rsp_t rsp
);
  import glmi_pkg::*;

  localparam int CW  = $clog2(SQ_RW + 1);
  localparam int RMW = SQ_RW + 1;   // remainder stays <= 2*root
  localparam int SHW = RMW + 2;

  logic [SQ_VW-1:0] v_r;
  logic [RMW-1:0]   rem_r;
  logic [SQ_RW-1:0] root_r;
  logic [CW-1:0]    cnt_r;
  logic             done_r;
  logic [SHW-1:0]   sh;
  logic [SHW-1:0]   trial;

  assign sh    = {rem_r, v_r[SQ_VW-1 -: 2]};
  assign trial = SHW'({root_r, 2'b01});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= !req.start && (cnt_r == CW'(1));
      if (req.start) begin
        v_r    <= req.radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= CW'(SQ_RW);
      end else if (cnt_r != '0) begin
        if (sh >= trial) begin
          rem_r  <= RMW'(sh - trial);
          root_r <= {root_r[SQ_RW-2:0], 1'b1};
        end else begin
          rem_r  <= sh[RMW-1:0];
          root_r <= {root_r[SQ_RW-2:0], 1'b0};
        end
        v_r   <= {v_r[SQ_VW-3:0], 2'b00};
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule

### design/galvo_linear_move_interpolator_core.sv
`timescale 1ns / 1ps
// channel | dir | tvalid/tready | tdata / tuser / tlast
// in_     | in  | in_tvalid/in_tready | tuser: opcode; tdata: move fields + now_ns
// out_    | out | out_tvalid/out_tready | tdata: galvo x/y, power, overflow; tlast: done
// cfg_    | in  | cfg_we (no ready)     | cfg_addr index, cfg_wdata value
//
// Move items only write the queue, or set the overflow flag when it is full. A tick during
// a move uses the shared bit-serial divider up to three times (fraction, y code, x code).
// A tick that starts a linear move also runs the 25-step root and the duration divide.
// Sync active-low reset; queue contents are left undefined.
// Input accepted only in idle; a finished result waits in the output register while
// the next item is taken. A stalled output holds the block in its emit step.
module galvo_linear_move_interpolator_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // tdata: is_rapid, pos_x, has_x, pos_y, has_y, feed_rate, has_feed,
  //        power_level, has_power, now_ns (lowest bit up), zero padded
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [135:0]                  in_tdata,
  input  logic                          in_tuser,   // opcode
  // tdata: galvo_x, galvo_y, laser_power, queue_overflow (lowest bit up)
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [47:0]                   out_tdata,
  output logic                          out_tlast,  // move_done
  input  logic                          cfg_we,
  input  logic [glmi_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [23:0]                   cfg_wdata
);
  import glmi_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic        is_rapid;
    logic        has_power;
    logic [7:0]  power;
    logic        has_feed;
    logic [23:0] feed;
    logic        has_y;
    logic [15:0] y;
    logic        has_x;
    logic [15:0] x;
  } qent_t;

  typedef enum logic [4:0] {
    S_IDLE, S_READ, S_APPLY, S_SQUARE, S_SUM, S_SQRT, S_LENMUL, S_DURGO,
    S_DURDIV, S_ELAPSED, S_FRACDIV, S_POS, S_MAPN, S_MAPA, S_DIVY, S_DIVX, S_EMIT
  } state_t;

  state_t state_r;

  // configuration
  logic [23:0] default_feed_r;
  logic [15:0] field_span_r;

  // queue control
  logic [AW-1:0] head_r, tail_r;
  logic [NW-1:0] count_r;
  logic          ovf_r;

  // move state
  logic [15:0] sx_r, sy_r, tx_r, ty_r;
  logic [23:0] cur_feed_r;
  logic        feed_set_r;
  logic [7:0]  cur_power_r;
  logic [63:0] tstart_r, now_r;
  logic [47:0] dur_r;
  logic        active_r;

  // datapath
  logic signed [16:0] dx_r, dy_r;
  logic [32:0] sqx_r, sqy_r;
  logic [SQ_RW-1:0] len_r;
  logic [54:0] prod_r;
  logic [16:0] f_r;
  logic [31:0] px_r, py_r;
  logic [47:0] nmx_r, nmy_r;
  logic [32:0] nx_div_r;
  logic        negx_r;
  logic [15:0] gx_r, gy_r;
  logic [7:0]  pwr_r;
  logic        done_r;

  // output register
  logic        out_valid_r;
  logic [47:0] out_data_r;
  logic        out_last_r;

  div_req_t div_req_r;
  div_rsp_t div_rsp;
  sq_req_t  sq_req_r;
  sq_rsp_t  sq_rsp;

  qent_t q_wdata, q_rdata;
  logic  q_we;
  logic  in_fire;
  logic  q_full;

  // comb helpers
  logic [23:0] feed_eff;
  logic [15:0] span_eff;
  logic [15:0] tx_nxt, ty_nxt;
  logic signed [16:0] dx_c, dy_c;
  logic signed [33:0] dxsq, dysq;
  logic [63:0] elapsed;
  logic signed [35:0] pxs, pys;
  logic [30:0] half;
  logic [47:0] full;
  logic [48:0] numy;
  logic signed [49:0] numx;

  function automatic logic [15:0] sat16(input logic [DIV_DW-1:0] q);
    return (|q[DIV_DW-1:16]) ? GALVO_MAX : q[15:0];
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign q_full    = (count_r == NW'(QUEUE_DEPTH));
  assign q_we      = in_fire && (in_tuser == OP_MOVE) && !q_full;

  assign q_wdata.is_rapid  = in_tdata[0];
  assign q_wdata.x         = in_tdata[16:1];
  assign q_wdata.has_x     = in_tdata[17];
  assign q_wdata.y         = in_tdata[33:18];
  assign q_wdata.has_y     = in_tdata[34];
  assign q_wdata.feed      = in_tdata[58:35];
  assign q_wdata.has_feed  = in_tdata[59];
  assign q_wdata.power     = in_tdata[67:60];
  assign q_wdata.has_power = in_tdata[68];

  glmi_ram #(.WIDTH($bits(qent_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail_r),
    .wdata (q_wdata),
    .raddr (head_r),
    .rdata (q_rdata)
  );

  glmi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  glmi_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sq_req_r),
    .rsp   (sq_rsp)
  );

  // zero feed or span behaves as one
  assign feed_eff = (cur_feed_r == '0) ? 24'd1 : cur_feed_r;
  assign span_eff = (field_span_r == '0) ? 16'd1 : field_span_r;

  // sticky coordinates for the move being loaded
  assign tx_nxt = q_rdata.has_x ? q_rdata.x : tx_r;
  assign ty_nxt = q_rdata.has_y ? q_rdata.y : ty_r;

  assign dx_c = $signed({1'b0, tx_r}) - $signed({1'b0, sx_r});
  assign dy_c = $signed({1'b0, ty_r}) - $signed({1'b0, sy_r});
  assign dxsq = dx_c * dx_c;
  assign dysq = dy_c * dy_c;

  assign elapsed = now_r - tstart_r;

  // P16 = start*65536 + delta*fraction
  assign pxs = $signed({4'b0, sx_r, 16'b0}) + 36'(dx_r * $signed({1'b0, f_r}));
  assign pys = $signed({4'b0, sy_r, 16'b0}) + 36'(dy_r * $signed({1'b0, f_r}));

  // round-half-up code numerators; division by span*65536 is a shift then /span
  assign half = {span_eff, 15'b0};
  assign full = {({span_eff, 16'b0} - {16'b0, span_eff}), 16'b0};
  assign numy = {1'b0, nmy_r} + 49'(half);
  assign numx = $signed({2'b0, full}) + $signed(50'(half)) - $signed({2'b0, nmx_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      default_feed_r <= DEFAULT_FEED_RST;
      field_span_r   <= FIELD_SPAN_RST;
      head_r         <= '0;
      tail_r         <= '0;
      count_r        <= '0;
      ovf_r          <= 1'b0;
      sx_r           <= '0;
      sy_r           <= '0;
      tx_r           <= '0;
      ty_r           <= '0;
      cur_feed_r     <= DEFAULT_FEED_RST;
      feed_set_r     <= 1'b0;
      cur_power_r    <= '0;
      tstart_r       <= '0;
      dur_r          <= '0;
      active_r       <= 1'b0;
      out_valid_r    <= 1'b0;
      div_req_r      <= '0;
      sq_req_r       <= '0;
    end else begin
      // start strobes last one cycle; no state raises them twice in a row
      if (div_req_r.start) begin
        div_req_r.start <= 1'b0;
      end
      if (sq_req_r.start) begin
        sq_req_r.start <= 1'b0;
      end

      // emit step handles its own slot release
      if (out_valid_r && out_tready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_addr)
          CFG_DEFAULT_FEED: begin
            default_feed_r <= cfg_wdata;
            if (!feed_set_r) begin
              cur_feed_r <= cfg_wdata;
            end
          end
          CFG_FIELD_SPAN: field_span_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_tuser == OP_MOVE) begin
              if (q_full) begin
                ovf_r <= 1'b1;
              end else begin
                tail_r  <= (tail_r == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
                count_r <= count_r + 1'b1;
              end
            end else begin
              now_r <= in_tdata[132:69];
              if (active_r) begin
                state_r <= S_ELAPSED;
              end else if (count_r != '0) begin
                state_r <= S_READ;
              end
            end
          end
        end
        S_READ: state_r <= S_APPLY;   // queue read data lands next cycle
        S_APPLY: begin
          head_r  <= (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
          count_r <= count_r - 1'b1;
          sx_r    <= tx_r;
          sy_r    <= ty_r;
          tx_r    <= tx_nxt;
          ty_r    <= ty_nxt;
          if (q_rdata.has_feed) begin
            cur_feed_r <= q_rdata.feed;
            feed_set_r <= 1'b1;
          end
          if (q_rdata.has_power) begin
            cur_power_r <= q_rdata.power;
          end
          if (q_rdata.is_rapid) begin
            px_r    <= {tx_nxt, 16'b0};
            py_r    <= {ty_nxt, 16'b0};
            pwr_r   <= '0;
            done_r  <= 1'b1;
            state_r <= S_MAPN;
          end else begin
            state_r <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          dx_r    <= dx_c;
          dy_r    <= dy_c;
          sqx_r   <= dxsq[32:0];
          sqy_r   <= dysq[32:0];
          state_r <= S_SUM;
        end
        S_SUM: begin
          sq_req_r.start    <= 1'b1;
          sq_req_r.radicand <= {({1'b0, sqx_r} + {1'b0, sqy_r}), 16'b0};
          state_r           <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_rsp.done) begin
            len_r   <= sq_rsp.root;
            state_r <= S_LENMUL;
          end
        end
        S_LENMUL: begin
          prod_r  <= 55'(len_r) * 55'(NS_PER_S);
          state_r <= S_DURGO;
        end
        S_DURGO: begin
          // floor(L*1e9/(feed*256)) = floor((L*1e9 >> 8)/feed)
          div_req_r.start    <= 1'b1;
          div_req_r.dividend <= DIV_DW'(prod_r[54:8]);
          div_req_r.divisor  <= DIV_VW'(feed_eff);
          state_r            <= S_DURDIV;
        end
        S_DURDIV: begin
          if (div_rsp.done) begin
            dur_r    <= div_rsp.quotient[47:0];
            tstart_r <= now_r;
            active_r <= 1'b1;
            state_r  <= S_ELAPSED;
          end
        end
        S_ELAPSED: begin
          if (elapsed > {16'b0, dur_r}) begin
            active_r <= 1'b0;
            px_r     <= {tx_r, 16'b0};
            py_r     <= {ty_r, 16'b0};
            pwr_r    <= cur_power_r;
            done_r   <= 1'b1;
            state_r  <= S_MAPN;
          end else if (dur_r == '0) begin
            f_r     <= '0;
            state_r <= S_POS;
          end else begin
            div_req_r.start    <= 1'b1;
            div_req_r.dividend <= {elapsed[47:0], 16'b0};
            div_req_r.divisor  <= dur_r;
            state_r            <= S_FRACDIV;
          end
        end
        S_FRACDIV: begin
          if (div_rsp.done) begin
            f_r     <= div_rsp.quotient[16:0];
            state_r <= S_POS;
          end
        end
        S_POS: begin
          px_r    <= pxs[31:0];
          py_r    <= pys[31:0];
          pwr_r   <= cur_power_r;
          done_r  <= 1'b0;
          state_r <= S_MAPN;
        end
        S_MAPN: begin
          // P*65535
          nmx_r   <= {px_r, 16'b0} - {16'b0, px_r};
          nmy_r   <= {py_r, 16'b0} - {16'b0, py_r};
          state_r <= S_MAPA;
        end
        S_MAPA: begin
          negx_r             <= numx[49];
          nx_div_r           <= numx[48:16];
          div_req_r.start    <= 1'b1;
          div_req_r.dividend <= DIV_DW'(numy[48:16]);
          div_req_r.divisor  <= DIV_VW'(span_eff);
          state_r            <= S_DIVY;
        end
        S_DIVY: begin
          if (div_rsp.done) begin
            gy_r <= sat16(div_rsp.quotient);
            if (negx_r) begin
              gx_r    <= '0;
              state_r <= S_EMIT;
            end else begin
              div_req_r.start    <= 1'b1;
              div_req_r.dividend <= DIV_DW'(nx_div_r);
              div_req_r.divisor  <= DIV_VW'(span_eff);
              state_r            <= S_DIVX;
            end
          end
        end
        S_DIVX: begin
          if (div_rsp.done) begin
            gx_r    <= sat16(div_rsp.quotient);
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {7'b0, ovf_r, pwr_r, gy_r, gx_r};
            out_last_r  <= done_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

### design/glmi_checker.sv
`timescale 1ns / 1ps
module glmi_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [47:0]  out_tdata
);
  import glmi_pkg::*;

  logic seen_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_ovf_r <= 1'b0;
    end else if (out_tvalid && out_tready && out_tdata[40]) begin
      seen_ovf_r <= 1'b1;
    end
  end

  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && seen_ovf_r |-> out_tdata[40])
    else $error("overflow flag dropped");

  a_move_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_MOVE) && !out_tvalid |=> !out_tvalid)
    else $error("move item produced a result");

endmodule

bind galvo_linear_move_interpolator_core glmi_checker u_glmi_checker (.*);

### tb/glmi_scoreboard.sv
`timescale 1ns / 1ps
module glmi_scoreboard (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [135:0] in_tdata,
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [47:0]  out_tdata,
  input  logic         out_tlast,
  input  logic         cfg_we,
  input  logic [glmi_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [23:0]  cfg_wdata,
  output int           fail_count,
  output int           pending,
  output int           result_count
);
  import glmi_pkg::*;

  localparam int DEPTH = 16;

  typedef struct packed {
    logic        rapid;
    logic [15:0] x;
    logic        hx;
    logic [15:0] y;
    logic        hy;
    logic [23:0] feed;
    logic        hf;
    logic [7:0]  pw;
    logic        hp;
  } move_t;

  typedef struct packed {
    logic [15:0] gx;
    logic [15:0] gy;
    logic [7:0]  pw;
    logic        done;
    logic        ovf;
  } point_t;

  point_t      expected_points[$];
  move_t       move_fifo[$];
  logic [23:0] dflt_feed;
  logic [15:0] span_reg;
  logic [15:0] sx, sy, tx, ty;
  logic [23:0] cur_feed;
  logic [7:0]  cur_pw;
  logic [63:0] t_start, t_len;
  logic        active, ovf_flag, feed_set;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic point_t to_codes(input longint px, input longint py,
                                      input logic [7:0] pw, input logic done);
    point_t p;
    longint span, den, half, gx, gy;
    span = (span_reg == 0) ? 1 : longint'(span_reg);
    den  = span * 65536;
    half = span * 32768;
    gx = 65535 * den - px * 65535 + half;
    gy = py * 65535 + half;
    gx = (gx < 0) ? 0 : gx / den;
    gy = gy / den;
    if (gx > 65535) gx = 65535;
    if (gy > 65535) gy = 65535;
    p.gx = gx[15:0];
    p.gy = gy[15:0];
    p.pw = pw;
    p.done = done;
    p.ovf = ovf_flag;
    return p;
  endfunction

  // one tick: start a queued move if idle (a rapid move emits its end point at once), then interpolate
  task automatic advance_tick(input logic [63:0] now);
    move_t  m;
    longint dx, dy;
    logic [63:0] d2, len, feed, e, f;
    if (!active) begin
      if (move_fifo.size() == 0) return;
      m = move_fifo.pop_front();
      sx = tx;
      sy = ty;
      if (m.hx) tx = m.x;
      if (m.hy) ty = m.y;
      if (m.hf) begin
        cur_feed = m.feed;
        feed_set = 1;
      end
      if (m.hp) cur_pw = m.pw;
      if (m.rapid) begin
        expected_points.push_back(to_codes(longint'(tx) <<< 16, longint'(ty) <<< 16, 8'd0, 1));
        return;
      end
      dx = longint'(tx) - longint'(sx);
      dy = longint'(ty) - longint'(sy);
      d2 = 64'(dx * dx) + 64'(dy * dy);
      len = int_sqrt(d2 << 16);
      feed = (cur_feed == 0) ? 64'd1 : 64'(cur_feed);
      t_len = len * 64'd1000000000 / (feed * 256);
      t_start = now;
      active = 1;
    end
    e = now - t_start;
    if (e > t_len) begin
      active = 0;
      expected_points.push_back(to_codes(longint'(tx) <<< 16, longint'(ty) <<< 16, cur_pw, 1));
      return;
    end
    f = (t_len == 0) ? 64'd0 : (e << 16) / t_len;
    dx = longint'(tx) - longint'(sx);
    dy = longint'(ty) - longint'(sy);
    expected_points.push_back(to_codes((longint'(sx) <<< 16) + dx * longint'(f),
                                       (longint'(sy) <<< 16) + dy * longint'(f), cur_pw, 0));
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    result_count = 0;
  end

  always @(posedge clk) begin
    move_t  m;
    point_t p;
    if (!rst_n) begin
      dflt_feed = DEFAULT_FEED_RST;
      span_reg = FIELD_SPAN_RST;
      move_fifo.delete();
      expected_points.delete();
      sx = 0; sy = 0; tx = 0; ty = 0;
      cur_feed = DEFAULT_FEED_RST;
      cur_pw = 0;
      t_start = 0;
      t_len = 0;
      active = 0;
      ovf_flag = 0;
      feed_set = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_DEFAULT_FEED) begin
          dflt_feed = cfg_wdata;
          if (!feed_set) cur_feed = dflt_feed;
        end else if (cfg_addr == CFG_FIELD_SPAN) begin
          span_reg = cfg_wdata[15:0];
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_MOVE) begin
          m = '{rapid: in_tdata[0], x: in_tdata[16:1], hx: in_tdata[17],
                y: in_tdata[33:18], hy: in_tdata[34], feed: in_tdata[58:35],
                hf: in_tdata[59], pw: in_tdata[67:60], hp: in_tdata[68]};
          if (move_fifo.size() >= DEPTH) ovf_flag = 1;
          else move_fifo.push_back(m);
        end else begin
          advance_tick(in_tdata[132:69]);
        end
      end
      if (out_tvalid && out_tready) begin
        result_count++;
        if (expected_points.size() == 0) begin
          report_mismatch("unexpected item count", 1, 0);
        end else begin
          p = expected_points.pop_front();
          if (out_tdata[15:0] !== p.gx) report_mismatch("galvo_x", out_tdata[15:0], p.gx);
          if (out_tdata[31:16] !== p.gy) report_mismatch("galvo_y", out_tdata[31:16], p.gy);
          if (out_tdata[39:32] !== p.pw) report_mismatch("laser_power", out_tdata[39:32], p.pw);
          if (out_tlast !== p.done) report_mismatch("move_done", out_tlast, p.done);
          if (out_tdata[40] !== p.ovf) report_mismatch("queue_overflow", out_tdata[40], p.ovf);
        end
      end
    end
    pending = expected_points.size();
  end

endmodule

### tb/galvo_linear_move_interpolator_core_tb.sv
`timescale 1ns / 1ps
module galvo_linear_move_interpolator_core_tb;
  import glmi_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // tdata: is_rapid, pos_x, has_x, pos_y, has_y, feed_rate, has_feed,
  //        power_level, has_power, now_ns (lowest bit up)
  logic [135:0] in_tdata;
  logic         in_tuser;     // opcode
  logic         out_tvalid;
  logic         out_tready;
  // tdata: galvo_x, galvo_y, laser_power, queue_overflow (lowest bit up)
  logic [47:0]  out_tdata;
  logic         out_tlast;    // move_done
  logic         cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [23:0]  cfg_wdata;

  int fail_count, pending, result_count;
  int n_moves, n_ticks, burst_left;
  logic [63:0] now_ns;        // running tick time
  logic hold_req, hold_done;  // long receiver hold-off handshake between processes

  galvo_linear_move_interpolator_core uut (.*);

  glmi_scoreboard chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_we, .cfg_addr, .cfg_wdata,
    .fail_count, .pending, .result_count
  );

  initial clk = 0;
  always #10 clk = ~clk;

  // watchdog: far above the slowest legal run
  initial begin
    #20ms;
    $display("timeout, %0d results still expected", pending);
    $display("FAIL");
    $finish;
  end

  // receiver: random stall pattern, plus one long hold-off on request
  always @(negedge clk) begin
    int k;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_done = 0;
    end else if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      for (k = 0; k < 3000; k++) @(negedge clk);
      hold_done = 1;
    end else begin
      case ($urandom_range(0, 3))
        0: out_tready <= 1'b0;
        1: out_tready <= ($urandom_range(0, 9) == 0);
        default: out_tready <= 1'b1;
      endcase
    end
  end

  // hand one item to the block; valid stays high within a burst
  task automatic send_item(input logic op, input logic [135:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= data;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (op == OP_MOVE) n_moves++;
    else n_ticks++;
  endtask

  task automatic send_move(input logic rapid, input logic [15:0] x, input logic hx,
                           input logic [15:0] y, input logic hy, input logic [23:0] feed,
                           input logic hf, input logic [7:0] pw, input logic hp);
    logic [135:0] d;
    d = '0;
    d[0] = rapid;
    d[16:1] = x;
    d[17] = hx;
    d[33:18] = y;
    d[34] = hy;
    d[58:35] = feed;
    d[59] = hf;
    d[67:60] = pw;
    d[68] = hp;
    d[132:69] = {$urandom, $urandom};  // ignored on moves
    send_item(OP_MOVE, d);
  endtask

  task automatic send_tick(input logic [63:0] t);
    logic [135:0] d;
    d = '0;
    d[68:0] = 69'({$urandom, $urandom, $urandom});  // move fields are ignored on ticks
    d[132:69] = t;
    send_item(OP_TICK, d);
  endtask

  // sender idles until every result is out, then covers the block's tail latency
  task automatic drain;
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (500) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [23:0] pick_feed;
    case ($urandom_range(0, 9))
      0: return 24'($urandom);          // any 24-bit value, very short moves
      1: return 24'd0;
      2: return 24'hFFFFFF;
      default: return 24'($urandom_range(2000, 600000));
    endcase
  endfunction

  // well-formed stretch: one to four moves (at times twenty), then ticks walking through them
  task automatic random_run(input int n_items);
    int i, nm, j;
    logic [63:0] step;
    i = 0;
    while (i < n_items) begin
      nm = ($urandom_range(0, 15) == 0) ? 20 : $urandom_range(1, 4);  // floods overflow queue
      for (j = 0; j < nm; j++) begin
        send_move($urandom_range(0, 4) == 0,
                  ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 3000)),
                  $urandom_range(0, 5) != 0,
                  ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 3000)),
                  $urandom_range(0, 5) != 0,
                  pick_feed(), $urandom_range(0, 2) != 0,
                  8'($urandom), $urandom_range(0, 2) != 0);
        i++;
      end
      for (j = 0; j < nm * 4 + 2; j++) begin
        case ($urandom_range(0, 19))
          0: now_ns = {$urandom, $urandom};             // jump anywhere
          1: now_ns = now_ns - 64'($urandom_range(1, 100000)); // time going backwards
          2: step = '0;
          default: begin
            step = 64'($urandom_range(0, 4000000));
            now_ns = now_ns + step;
          end
        endcase
        send_tick(now_ns);
        i++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = OP_MOVE;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = CFG_DEFAULT_FEED;
    cfg_wdata = '0;
    hold_req = 0;
    n_moves = 0;
    n_ticks = 0;
    burst_left = 0;
    now_ns = 0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: idle tick on an empty queue, field corners, late default feed
    send_tick(64'd5);
    drain();
    write_reg(CFG_DEFAULT_FEED, 24'd128000);  // no move has set feed yet
    send_move(1, 16'hFFFF, 1, 16'hFFFF, 1, 24'd0, 0, 8'hFF, 1);  // rapid to the far corner
    send_tick(64'd100);
    send_move(0, 16'h0000, 1, 16'h0000, 1, 24'd0, 0, 8'd0, 0);   // linear, default feed
    send_tick(64'd1000);
    send_tick(64'd1000 + 64'd500000000);
    send_tick(64'hFFFF_FFFF_FFFF_FFFF);
    send_move(0, 16'd2560, 1, 16'd0, 0, 24'hFFFFFF, 1, 8'd0, 1); // max feed, power 0
    send_tick(64'd0);
    send_tick(64'd1);
    send_move(0, 16'd0, 0, 16'd0, 0, 24'd0, 0, 8'd0, 0);         // zero length, all sticky
    send_tick(64'd7);
    send_tick(64'd8);
    send_move(0, 16'd100, 1, 16'd40000, 1, 24'd0, 1, 8'h5A, 1);  // zero feed
    send_tick(64'd10);
    send_tick(64'd9);                                            // backwards: ends
    drain();

    // register settings, the extremes among them
    write_reg(CFG_FIELD_SPAN, 24'd0);
    write_reg(CFG_DEFAULT_FEED, 24'd0);
    random_run(90);
    drain();
    write_reg(CFG_FIELD_SPAN, 24'hFFFFFF);  // upper bits fall off the 16-bit register
    write_reg(CFG_DEFAULT_FEED, 24'hFFFFFF);
    hold_req = 1;  // long receiver hold-off while items keep coming
    random_run(150);
    drain();
    write_reg(CFG_FIELD_SPAN, 24'd1);
    write_reg(CFG_DEFAULT_FEED, 24'd1);
    random_run(90);
    drain();
    write_reg(CFG_FIELD_SPAN, 24'd64000);
    write_reg(CFG_DEFAULT_FEED, 24'd256000);
    random_run(200);
    drain();
    write_reg(CFG_FIELD_SPAN, 24'($urandom_range(1000, 65535)));
    write_reg(CFG_DEFAULT_FEED, 24'($urandom));
    random_run(150);
    drain();

    $display("covered %0d moves and %0d ticks, %0d points checked", n_moves, n_ticks,
             result_count);
    $display("span and default feed went through zero, one, max and nominal settings");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
design/glmi_pkg.sv
design/glmi_ram.sv
design/glmi_div.sv
design/glmi_sqrt.sv
design/galvo_linear_move_interpolator_core.sv
design/glmi_checker.sv
tb/glmi_scoreboard.sv
tb/galvo_linear_move_interpolator_core_tb.sv
